[hdl/msvs_pkg.sv]
// ----------------------------------------------------------------------------
// msvs_pkg: shared types and constants for the min-stamp victim selector
// Holds the slot count, field widths, command and status codes, and the
// structs that pass between the controller and the slot cells.
// ----------------------------------------------------------------------------
package msvs_pkg;

  localparam int SLOTS   = 8;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int PAGE_W  = 20;
  localparam int STAMP_W = 8;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 4;

  localparam logic [CMD_W-1:0] CMD_MAP    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // Contents of one slot
  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  // Running search result handed from cell to cell
  typedef struct packed {
    logic               found;
    logic               hit;
    logic [STAMP_W-1:0] stamp;
    logic [PAGE_W-1:0]  page;
    logic [IDX_W-1:0]   idx;
  } scan_t;

  // Broadcast controls from the controller to every cell
  typedef struct packed {
    logic               map_en;
    logic               upd_en;
    logic               shift_en;
    logic [PAGE_W-1:0]  key_page;
    logic [STAMP_W-1:0] key_stamp;
    logic [IDX_W-1:0]   tail_idx;
    logic [IDX_W-1:0]   vict_idx;
  } cell_ctl_t;

endpackage

[hdl/msvs_cell.sv]
// ----------------------------------------------------------------------------
// msvs_cell: one slot of the page table
// Stores a page and its stamp, loads on map, rewrites the stamp on update,
// takes its upper neighbor's contents on removal, and folds itself into the
// registered search result passed down the chain.
// ----------------------------------------------------------------------------
module msvs_cell
  import msvs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  slot_t            nb,
  input  scan_t            carry_in,
  output slot_t            slot,
  output scan_t            carry_out
);

  logic               valid_r, valid_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  scan_t              carry_r, carry_nxt;
  logic               match;

  assign match = valid_r && (page_r == ctl.key_page);

  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    stamp_nxt = stamp_r;
    if (ctl.map_en && (cell_idx == ctl.tail_idx)) begin
      valid_nxt = 1'b1;
      page_nxt  = ctl.key_page;
      stamp_nxt = ctl.key_stamp;
    end else if (ctl.upd_en && match) begin
      stamp_nxt = ctl.key_stamp;
    end else if (ctl.shift_en && (cell_idx >= ctl.vict_idx)) begin
      // close the gap: take the neighbor above
      valid_nxt = nb.valid;
      page_nxt  = nb.page;
      stamp_nxt = nb.stamp;
    end
  end

  // strict less-than keeps the older entry on a tie
  always_comb begin
    carry_nxt     = carry_in;
    carry_nxt.hit = carry_in.hit | match;
    if (valid_r && (!carry_in.found || (stamp_r < carry_in.stamp))) begin
      carry_nxt.found = 1'b1;
      carry_nxt.stamp = stamp_r;
      carry_nxt.page  = page_r;
      carry_nxt.idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      carry_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    stamp_r <= stamp_nxt;
  end

  assign slot.valid = valid_r;
  assign slot.page  = page_r;
  assign slot.stamp = stamp_r;
  assign carry_out  = carry_r;

endmodule

[hdl/msvs_ctrl.sv]
// ----------------------------------------------------------------------------
// msvs_ctrl: command sequencer and result register
// Accepts commands, tracks the page count, times the search down the cell
// chain and holds each result until the output side takes it.
// ----------------------------------------------------------------------------
module msvs_ctrl
  import msvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,
  output logic [23:0] out_tdata,
  input  scan_t       scan_res,
  output cell_ctl_t   ctl
);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CMD_W-1:0]   cmd_r;
  logic [PAGE_W-1:0]  page_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [PAGE_W-1:0]  victim_r, victim_nxt;
  logic [OCC_W-1:0]   occ_r;
  logic               load_out;

  logic [CMD_W-1:0]   in_cmd;
  logic [PAGE_W-1:0]  in_page;
  logic [STAMP_W-1:0] in_stamp;
  logic               in_fire, out_free, full, empty, scan_last;

  assign in_cmd    = in_tuser;
  assign in_page   = in_tdata[PAGE_W-1:0];
  assign in_stamp  = in_tdata[PAGE_W+STAMP_W-1:PAGE_W];
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(SLOTS));
  assign empty     = (count_r == '0);
  assign scan_last = (cnt_r == IDX_W'(SLOTS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && ((in_cmd == CMD_UPDATE) || ((in_cmd == CMD_VICTIM) && !empty)))
          state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctl.map_en    = 1'b0;
    ctl.upd_en    = 1'b0;
    ctl.shift_en  = 1'b0;
    ctl.key_page  = page_r;
    ctl.key_stamp = stamp_r;
    ctl.tail_idx  = count_r[IDX_W-1:0];
    ctl.vict_idx  = scan_res.idx;
    cnt_nxt       = '0;
    count_nxt     = count_r;
    load_out      = 1'b0;
    status_nxt    = ST_OK;
    victim_nxt    = '0;
    unique case (state_r)
      S_IDLE: begin
        ctl.key_page  = in_page;
        ctl.key_stamp = in_stamp;
        if (in_fire) begin
          case (in_cmd)
            CMD_MAP: begin
              load_out = 1'b1;
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ctl.map_en = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
              end
            end
            CMD_UPDATE: ;
            CMD_VICTIM: begin
              if (empty) begin
                load_out   = 1'b1;
                status_nxt = ST_EMPTY;
              end
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        // rewrite matching stamps once, at the start of the search
        ctl.upd_en = (cmd_r == CMD_UPDATE) && (cnt_r == '0);
      end
      S_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          if (cmd_r == CMD_UPDATE) begin
            status_nxt = scan_res.hit ? ST_OK : ST_NOTFOUND;
          end else begin
            ctl.shift_en = 1'b1;
            victim_nxt   = scan_res.page;
            count_nxt    = count_r - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_cmd;
      page_r  <= in_page;
      stamp_r <= in_stamp;
    end
    if (load_out) begin
      status_r <= status_nxt;
      victim_r <= victim_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {occ_r, victim_r};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOTS))
    else $error("page count above slot count");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift_en |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("removal did not drop the page count");

  a_remove_found: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift_en |-> (scan_res.found && !empty))
    else $error("removal without a resident victim");

  a_map_inc: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.map_en |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("map did not raise the page count");
`endif

endmodule

[hdl/min_stamp_page_victim_select.sv]
// ----------------------------------------------------------------------------
// min_stamp_page_victim_select: page table with smallest-stamp victim choice
// Top level: command sequencer plus a chain of slot cells.
// ----------------------------------------------------------------------------
// Keeps up to SLOTS resident pages (msvs_pkg) in insertion order, each with an
// 8-bit usage stamp. A map command appends a page (status full when no slot
// is free), an update command rewrites the stamp of every matching page
// (status not found when none matches), and a victim command removes the page
// with the smallest stamp, the oldest one on a tie, and returns its number
// (status empty when the table is empty). Every command yields exactly one
// result transfer carrying the occupancy after the command. Map, victim on an
// empty table and the unused command code present their result in the cycle
// after the input transfer. Update and victim on a non-empty table search first:
// the search result travels down the chain of SLOTS cells through one register
// per cell; then, once the output register is free, the result is loaded and the
// removal shifts the younger pages down. A new command is taken only in idle and
// when the output register is empty or its result is being taken.
// ----------------------------------------------------------------------------
module min_stamp_page_victim_select
  import msvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic [31:0] in_tdata,   // [19:0] page_number, [27:20] stamp, [31:28] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [23:0] out_tdata   // [19:0] victim_page, [23:20] occupancy
);

  cell_ctl_t ctl;
  scan_t     carry [SLOTS+1];
  slot_t     slots [SLOTS+1];

  // seed of the search: nothing found, no hit
  assign carry[0] = '0;
  // above the top cell there is only an empty slot
  assign slots[SLOTS] = '0;

  msvs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .scan_res   (carry[SLOTS]),
    .ctl        (ctl)
  );

  // Slot 0 holds the oldest page; each cell hands its search result up the
  // chain and takes its upper neighbor's contents when a page is removed.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    msvs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(i)),
      .ctl       (ctl),
      .nb        (slots[i+1]),
      .carry_in  (carry[i]),
      .slot      (slots[i]),
      .carry_out (carry[i+1])
    );
  end

endmodule

[test/min_stamp_page_victim_select_test.sv]
// ----------------------------------------------------------------------------
// min_stamp_page_victim_select_test: self-checking bench for the victim selector
// Runs a short table of directed commands, then a long random mix of map,
// update and victim commands with random idle on both streams. A behavioral
// copy of the resident-page table predicts every result transfer.
// ----------------------------------------------------------------------------
module min_stamp_page_victim_select_test
  import msvs_pkg::*;
;

  // The fourth command code has no function; the block must ignore it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RAND_COMMANDS = 1450;
  // Settle time after the last result: one full scan plus margin
  localparam int DRAIN_CYCLES  = SLOTS + 6;
  localparam int POOL_SIZE     = 16;

  // One result transfer: status in tuser, victim page and occupancy in tdata
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PAGE_W-1:0]  victim;
    logic [OCC_W-1:0]   occ;
  } page_result_t;

  // One directed command; typed rows carry a hand-written result
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
    logic               typed;
    logic [STAT_W-1:0]  status;
    logic [PAGE_W-1:0]  victim;
    logic [OCC_W-1:0]   occ;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;    // [1:0] command
  logic [31:0] in_tdata;    // [19:0] page_number, [27:20] stamp, [31:28] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [1:0]  out_tuser;   // [1:0] status
  logic [23:0] out_tdata;   // [19:0] victim_page, [23:20] occupancy

  // Behavioral copy of the resident-page table, oldest page at index 0
  logic [PAGE_W-1:0]  resident_page  [SLOTS];
  logic [STAMP_W-1:0] resident_stamp [SLOTS];
  int                 resident_count = 0;

  page_result_t       pending_results [$];
  logic [PAGE_W-1:0]  page_pool [POOL_SIZE];

  int errors        = 0;
  int commands_sent = 0;
  int results_seen  = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  bit burst_mode    = 1'b0;

  // Directed commands: empty-table corners, field extremes, duplicates,
  // filling to full, a stamp tie, and draining back to empty.
  directed_row_t directed_rows [25] = '{
    '{CMD_VICTIM, 20'h00000, 8'h00, 1'b1, ST_EMPTY,    20'h0, 4'd0},
    '{CMD_UPDATE, 20'h12345, 8'h07, 1'b1, ST_NOTFOUND, 20'h0, 4'd0},
    '{CMD_UNUSED, 20'hFFFFF, 8'hFF, 1'b1, ST_OK,       20'h0, 4'd0},
    '{CMD_MAP,    20'h00000, 8'h00, 1'b1, ST_OK,       20'h0, 4'd1},
    '{CMD_MAP,    20'hFFFFF, 8'hFF, 1'b1, ST_OK,       20'h0, 4'd2},
    '{CMD_MAP,    20'hAAAAA, 8'h55, 1'b1, ST_OK,       20'h0, 4'd3},
    '{CMD_MAP,    20'h55555, 8'hAA, 1'b1, ST_OK,       20'h0, 4'd4},
    '{CMD_MAP,    20'hAAAAA, 8'h10, 1'b1, ST_OK,       20'h0, 4'd5},
    '{CMD_MAP,    20'h00001, 8'h80, 1'b1, ST_OK,       20'h0, 4'd6},
    '{CMD_MAP,    20'h80000, 8'h01, 1'b1, ST_OK,       20'h0, 4'd7},
    '{CMD_MAP,    20'h7FFFF, 8'hFE, 1'b1, ST_OK,       20'h0, 4'd8},
    '{CMD_MAP,    20'h33333, 8'h33, 1'b1, ST_FULL,     20'h0, 4'd8},
    '{CMD_UPDATE, 20'hAAAAA, 8'h00, 1'b0, ST_OK,       20'h0, 4'd0},
    '{CMD_UPDATE, 20'h44444, 8'h44, 1'b1, ST_NOTFOUND, 20'h0, 4'd8},
    '{CMD_UNUSED, 20'h00000, 8'h00, 1'b1, ST_OK,       20'h0, 4'd8},
    '{CMD_VICTIM, 20'h00000, 8'h00, 1'b0, ST_OK,       20'h0, 4'd0},
    '{CMD_VICTIM, 20'hFFFFF, 8'hFF, 1'b0, ST_OK,       20'h0, 4'd0},
    '{CMD_VICTIM, 20'h00000, 8'h00, 1'b0, ST_OK,       20'h0, 4'd0},
    '{CMD_UPDATE, 20'hFFFFF, 8'h00, 1'b0, ST_OK,       20'h0, 4'd0},
    '{CMD_VICTIM, 20'h00000, 8'h00, 1'b0, ST_OK,       20'h0, 4'd0},
    '{CMD_VICTIM, 20'h00000, 8'h00, 1'b0, ST_OK,       20'h0, 4'd0},
    '{CMD_VICTIM, 20'h00000, 8'h00, 1'b0, ST_OK,       20'h0, 4'd0},
    '{CMD_VICTIM, 20'h00000, 8'h00, 1'b0, ST_OK,       20'h0, 4'd0},
    '{CMD_VICTIM, 20'h00000, 8'h00, 1'b0, ST_OK,       20'h0, 4'd0},
    '{CMD_VICTIM, 20'h00000, 8'h00, 1'b1, ST_EMPTY,    20'h0, 4'd0}
  };

  min_stamp_page_victim_select dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Apply one command to the table copy and return the result it causes
  function automatic page_result_t apply_page_command(input logic [CMD_W-1:0] cmd,
      input logic [PAGE_W-1:0] page, input logic [STAMP_W-1:0] stamp);
    page_result_t res;
    int           oldest_min;
    logic         hit;
    res        = '0;
    res.status = ST_OK;
    oldest_min = 0;
    hit        = 1'b0;
    case (cmd)
      CMD_MAP: begin
        if (resident_count >= SLOTS) begin
          res.status = ST_FULL;
        end else begin
          resident_page[resident_count]  = page;
          resident_stamp[resident_count] = stamp;
          resident_count++;
        end
      end
      CMD_UPDATE: begin
        // every duplicate entry of the page takes the new stamp
        for (int i = 0; i < resident_count; i++) begin
          if (resident_page[i] == page) begin
            resident_stamp[i] = stamp;
            hit = 1'b1;
          end
        end
        if (!hit) res.status = ST_NOTFOUND;
      end
      CMD_VICTIM: begin
        if (resident_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // strict compare keeps the oldest page on a tie
          for (int i = 1; i < resident_count; i++) begin
            if (resident_stamp[i] < resident_stamp[oldest_min]) oldest_min = i;
          end
          res.victim = resident_page[oldest_min];
          for (int i = oldest_min; i < resident_count - 1; i++) begin
            resident_page[i]  = resident_page[i + 1];
            resident_stamp[i] = resident_stamp[i + 1];
          end
          resident_count--;
        end
      end
      default: ;
    endcase
    res.occ = resident_count[OCC_W-1:0];
    return res;
  endfunction

  // Mostly short gaps, a few long ones; none at all in a burst stretch
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
      input int unsigned want);
    $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  // Drive one command; entered and left at a falling edge. The prediction
  // is made at the edge where the input transfer happens.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] page,
      input logic [STAMP_W-1:0] stamp, input logic typed, input page_result_t typed_res);
    int           gap;
    page_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, stamp, page};
    do @(posedge clk); while (!in_tready);
    predicted = apply_page_command(cmd, page, stamp);
    pending_results.push_back(typed ? typed_res : predicted);
    commands_sent++;
    @(negedge clk);
  endtask

  // Result stream: compare each transfer with the oldest pending result
  always @(posedge clk) begin : result_check
    page_result_t got;
    page_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.victim = out_tdata[19:0];
      got.occ    = out_tdata[23:20];
      status_seen[got.status]++;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", got, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.victim !== want.victim) report_mismatch("victim_page", got.victim, want.victim);
        if (got.occ !== want.occ) report_mismatch("occupancy", got.occ, want.occ);
      end
    end
  end

  // Result backpressure: ready runs, short stalls, the odd long stall,
  // and now and then a long stretch with no stall at all
  initial begin : result_backpressure
    int roll;
    int run;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        out_tready <= 1'b1;
        run = $urandom_range(50, 200);
      end else if (roll < 60) begin
        out_tready <= 1'b1;
        run = $urandom_range(1, 8);
      end else if (roll < 92) begin
        out_tready <= 1'b0;
        run = $urandom_range(1, 3);
      end else begin
        out_tready <= 1'b0;
        run = $urandom_range(8, 30);
      end
      repeat (run) @(negedge clk);
    end
  end

  // Command stream: directed table, then the random mix
  initial begin : command_stream
    page_result_t       typed_res;
    logic [CMD_W-1:0]   cmd;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
    int                 random_done;
    int                 segment_left;
    int                 roll;
    int                 map_top;
    int                 update_top;
    bit                 fill_phase;
    random_done  = 0;
    segment_left = 0;
    fill_phase   = 1'b1;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tuser     = '0;
    in_tdata     = '0;
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = PAGE_W'($urandom);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      typed_res.status = directed_rows[i].status;
      typed_res.victim = directed_rows[i].victim;
      typed_res.occ    = directed_rows[i].occ;
      send_command(directed_rows[i].cmd, directed_rows[i].page, directed_rows[i].stamp,
                   directed_rows[i].typed, typed_res);
    end

    // Alternate fill and drain stretches so the table swings between
    // empty and full; a quarter of the stretches run without input gaps.
    while (random_done < RAND_COMMANDS) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(20, 60);
        fill_phase   = ($urandom_range(0, 1) == 1);
        burst_mode   = ($urandom_range(0, 3) == 0);
      end
      segment_left--;
      map_top    = fill_phase ? 56 : 24;
      update_top = fill_phase ? 76 : 46;
      roll = $urandom_range(0, 99);
      if (roll < 4) cmd = CMD_UNUSED;
      else if (roll < map_top) cmd = CMD_MAP;
      else if (roll < update_top) cmd = CMD_UPDATE;
      else cmd = CMD_VICTIM;

      // resident pages make updates hit and maps duplicate; the pool
      // brings back evicted pages; full-range values toggle every bit
      roll = $urandom_range(0, 99);
      if (roll < 30) page = PAGE_W'($urandom);
      else if (roll < 70 && resident_count > 0)
        page = resident_page[$urandom_range(0, resident_count - 1)];
      else page = page_pool[$urandom_range(0, POOL_SIZE - 1)];

      // narrow stamps force ties; extremes hit the compare boundaries
      roll = $urandom_range(0, 99);
      if (roll < 50) stamp = STAMP_W'($urandom);
      else if (roll < 80) stamp = STAMP_W'($urandom_range(0, 3));
      else stamp = roll[0] ? 8'hFF : 8'h00;

      send_command(cmd, page, stamp, 1'b0, '0);
      random_done++;
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands and %0d result transfers, directed corners first.",
             commands_sent, results_seen);
    $display("Status mix: ok %0d, empty %0d, full %0d, not found %0d; mismatches %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_NOTFOUND], errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run
  initial begin : run_limit
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
hdl/msvs_pkg.sv
hdl/msvs_cell.sv
hdl/msvs_ctrl.sv
hdl/min_stamp_page_victim_select.sv
test/min_stamp_page_victim_select_test.sv
